// ===== sv/product_form_cholesky_factor_assert.svh =====
// Assertion macros used by the checker file
`ifndef PRODUCT_FORM_CHOLESKY_FACTOR_ASSERT_SVH
`define PRODUCT_FORM_CHOLESKY_FACTOR_ASSERT_SVH
// implication checked every clock outside reset
`define PFC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// consequence checked in the cycle after the antecedent
`define PFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== sv/pfc_pkg.sv =====
// Package: widths, codes and fixed-point helpers for the product-form Cholesky block
`default_nettype none
package pfc_pkg;
	localparam int MAX_ROWS_DEF  = 64;
	localparam int MAX_COLS_DEF  = 8;
	localparam int FRAC_BITS_DEF = 16;
	localparam int KIND_W  = 2;
	localparam int COL_W   = 3;
	localparam int ROW_W   = 6;
	localparam int DATA_W  = 32;
	localparam int L_W     = 31;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 7;

	localparam logic [KIND_W-1:0] KIND_WR_V    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WR_W    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_START   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_READ    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [COL_W-1:0]  column_index;
		logic [ROW_W-1:0]  row_index;
		logic signed [DATA_W-1:0] data_value;
	} req_t;

	typedef struct packed {
		logic [L_W-1:0]           l_value;
		logic signed [DATA_W-1:0] b_value;
		logic                     status;
	} rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		if (x > 66'sd2147483647) return 32'sh7fffffff;
		if (x < -66'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction
endpackage
`default_nettype wire

// ===== sv/pfc_stream_if.sv =====
// Valid/ready stream interface
`default_nettype none
interface pfc_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/product_form_cholesky_factor.sv =====
// Top level: product-form Cholesky factorization engine on a single V/L/B memory set
// channel | dir | payload                                  | accepted when
// req     | in  | kind, column_index, row_index, data_value | valid & ready
// rsp     | out | l_value, b_value, status                  | valid & ready
// A load is written when it is accepted; a read passes the memory read register, then the output register.
// A start runs a sequencer built around a bit-serial root and a bit-serial divider:
// it factors each column row by row, then updates every later column row by row.
// Reset clears control and the failure flag; memories need no clearing.
// A waiting result in the output register holds off all requests.
`default_nettype none
module product_form_cholesky_factor
	import pfc_pkg::*;
#(
	parameter int MAX_ROWS  = MAX_ROWS_DEF,
	parameter int MAX_COLS  = MAX_COLS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [pfc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [pfc_pkg::CFG_DAT_W-1:0] cfg_data,
	pfc_stream_if.sink                 req,
	pfc_stream_if.source               rsp
);
	localparam int RA = $clog2(MAX_ROWS) > 0 ? $clog2(MAX_ROWS) : 1;
	localparam int CA = $clog2(MAX_COLS) > 0 ? $clog2(MAX_COLS) : 1;
	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW = RA + CA;
	localparam int RW = $clog2(MAX_ROWS + 1);
	localparam int CW = $clog2(MAX_COLS + 1);
	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

	// state codes
	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_RDWAIT = 5'd1;
	localparam logic [4:0] ST_COLBEG = 5'd2;
	localparam logic [4:0] ST_FRD    = 5'd3;
	localparam logic [4:0] ST_FVV    = 5'd4;
	localparam logic [4:0] ST_FAVV   = 5'd5;
	localparam logic [4:0] ST_FT     = 5'd6;
	localparam logic [4:0] ST_FSQ    = 5'd7;
	localparam logic [4:0] ST_FAV    = 5'd8;
	localparam logic [4:0] ST_FDIV   = 5'd9;
	localparam logic [4:0] ST_FBB    = 5'd10;
	localparam logic [4:0] ST_FWR    = 5'd11;
	localparam logic [4:0] ST_URD    = 5'd12;
	localparam logic [4:0] ST_UVS    = 5'd13;
	localparam logic [4:0] ST_UDIV   = 5'd14;
	localparam logic [4:0] ST_UXB    = 5'd15;
	localparam logic [4:0] ST_UWR    = 5'd16;
	localparam logic [4:0] ST_DONE   = 5'd17;
	localparam logic [4:0] ST_URD2   = 5'd18;

	logic [4:0] st_q;
	logic [RW-1:0] rows_q;
	logic [CW-1:0] cols_q;
	logic failed_q;

	logic signed [31:0] v_mem [DEPTH];
	logic signed [31:0] l_mem [DEPTH];
	logic signed [31:0] b_mem [DEPTH];
	logic signed [31:0] w_mem [MAX_COLS];

	logic [AW-1:0] raddr, vwaddr, lbwaddr;
	logic v_we, lb_we;
	logic signed [31:0] v_wd, l_wd, b_wd;
	logic signed [31:0] v_rd_q, vx_rd_q, l_rd_q, b_rd_q, w_rd_q;
	logic [AW-1:0] raddr2;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= RW'(MAX_ROWS);
			cols_q <= CW'(MAX_COLS);
		end else if (cfg_we) begin
			if (cfg_index == REG_ROWS) begin
				if (cfg_data == '0) rows_q <= RW'(1);
				else if ({25'd0, cfg_data} > MAX_ROWS) rows_q <= RW'(MAX_ROWS);
				else rows_q <= RW'(cfg_data);
			end else begin
				if (cfg_data[3:0] == '0) cols_q <= CW'(1);
				else if ({28'd0, cfg_data[3:0]} > MAX_COLS) cols_q <= CW'(MAX_COLS);
				else cols_q <= CW'(cfg_data[3:0]);
			end
		end
	end

	// memories: port A reads raddr for V/L/B, port B reads raddr2 for V
	always_ff @(posedge clk) begin
		if (v_we) v_mem[vwaddr] <= v_wd;
		if (lb_we) begin
			l_mem[lbwaddr] <= l_wd;
			b_mem[lbwaddr] <= b_wd;
		end
		v_rd_q  <= v_mem[raddr];
		vx_rd_q <= v_mem[raddr2];
		l_rd_q  <= l_mem[raddr];
		b_rd_q  <= b_mem[raddr];
		if (req.valid && req.ready && req.data.kind == KIND_WR_W
			&& {29'd0, req.data.column_index} < MAX_COLS)
			w_mem[CA'(req.data.column_index)] <= req.data.data_value;
		w_rd_q <= w_mem[raddr[AW-1:RA]];
	end

	// shared multiplier, one registered product
	logic signed [31:0] ma, mb, mprod_q;
	logic signed [63:0] mfull;
	assign mfull = 64'(ma) * 64'(mb);
	always_ff @(posedge clk) mprod_q <= sat32(66'(mfull >>> FRAC_BITS));

	// bit-serial square root
	logic [63:0] sq_x_q, sq_r_q, sq_bit_q;
	// bit-serial divider on magnitudes
	logic [63:0] dv_num_q, dv_rem_q, dv_q_q;
	logic [31:0] dv_den_q;
	logic dv_neg_q;
	logic [6:0] cnt_q;

	logic [CA-1:0] ci_q, cj_q;
	logic [RA-1:0] r_q;
	logic signed [31:0] alpha_q, vr_q, xr_q, lr_q, br_q, s_q, tmp_q;
	rsp_t rsp_q;
	logic rsp_v_q;
	logic rd_in_q;

	logic acc;
	assign acc = req.valid && req.ready;
	assign req.ready = (st_q == ST_IDLE) && !rsp_v_q;
	assign rsp.valid = rsp_v_q;
	assign rsp.data  = rsp_q;

	logic in_range;
	assign in_range = {29'd0, req.data.column_index} < MAX_COLS
		&& {26'd0, req.data.row_index} < MAX_ROWS;

	function automatic logic [AW-1:0] adr(input logic [CA-1:0] c, input logic [RA-1:0] r);
		return {c, r};
	endfunction

	logic [63:0] rem_sh;
	logic [63:0] sq_try;
	assign rem_sh = {dv_rem_q[62:0], dv_num_q[63]};
	assign sq_try = sq_r_q + sq_bit_q;

	// port and multiplier operand selection
	always_comb begin
		raddr = adr(ci_q, r_q);
		raddr2 = adr(cj_q, r_q);
		if (st_q == ST_IDLE) begin
			raddr = adr(CA'(req.data.column_index), RA'(req.data.row_index));
		end
		v_we = 1'b0; vwaddr = adr(cj_q, r_q); v_wd = tmp_q;
		lb_we = 1'b0; lbwaddr = adr(ci_q, r_q); l_wd = lr_q; b_wd = tmp_q;
		if (st_q == ST_IDLE && acc && req.data.kind == KIND_WR_V && in_range) begin
			v_we = 1'b1;
			vwaddr = adr(CA'(req.data.column_index), RA'(req.data.row_index));
			v_wd = req.data.data_value;
		end
		if (st_q == ST_FWR) lb_we = 1'b1;
		if (st_q == ST_UWR) v_we = 1'b1;
		ma = vr_q; mb = vr_q;
		unique case (st_q)
			// v*v straight from the read port
			ST_FVV:  begin ma = v_rd_q; mb = v_rd_q; end
			ST_FAVV: begin ma = alpha_q; mb = mprod_q; end
			ST_FAV:  begin ma = alpha_q; mb = vr_q; end
			ST_FBB:  begin ma = tmp_q; mb = tmp_q; end
			ST_UVS:  begin ma = vr_q; mb = s_q; end
			ST_UXB:  begin ma = tmp_q; mb = br_q; end
			default: begin ma = vr_q; mb = vr_q; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			rsp_v_q <= 1'b0;
			failed_q <= 1'b0;
			ci_q <= '0; cj_q <= '0; r_q <= '0; cnt_q <= '0;
			rd_in_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) rsp_v_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (acc) begin
						if (req.data.kind == KIND_READ) begin
							rd_in_q <= in_range;
							st_q <= ST_RDWAIT;
						end else if (req.data.kind == KIND_START) begin
							failed_q <= 1'b0;
							ci_q <= '0;
							r_q <= '0;
							st_q <= ST_COLBEG;
						end
					end
				end
				ST_RDWAIT: begin
					rsp_q.l_value <= rd_in_q ? l_rd_q[L_W-1:0] : '0;
					rsp_q.b_value <= rd_in_q ? b_rd_q : '0;
					rsp_q.status <= failed_q;
					rsp_v_q <= 1'b1;
					st_q <= ST_IDLE;
				end
				ST_COLBEG: begin
					// raddr column ci, weight read issued here, used in ST_FRD
					st_q <= ST_FRD;
					r_q <= '0;
				end
				ST_FRD: begin
					if (r_q == '0) alpha_q <= sat32(-66'(w_rd_q));
					st_q <= ST_FVV;
				end
				ST_FVV: begin
					vr_q <= v_rd_q;
					st_q <= ST_FAVV;
				end
				ST_FAVV: st_q <= ST_FT; // mprod = v*v here, next alpha*vv
				ST_FT: begin
					if (sat32(66'(ONE) - 66'(mprod_q)) <= 0) begin
						failed_q <= 1'b1;
						st_q <= ST_DONE;
					end else begin
						sq_x_q <= {32'd0, sat32(66'(ONE) - 66'(mprod_q))} << FRAC_BITS;
						sq_r_q <= '0;
						sq_bit_q <= 64'd1 << 62;
						st_q <= ST_FSQ;
					end
				end
				ST_FSQ: begin
					if (sq_bit_q == '0) begin
						lr_q <= sq_r_q[31:0];
						st_q <= ST_FAV;
					end else begin
						if (sq_x_q >= sq_try) begin
							sq_x_q <= sq_x_q - sq_try;
							sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
						end else begin
							sq_r_q <= sq_r_q >> 1;
						end
						sq_bit_q <= sq_bit_q >> 2;
					end
				end
				ST_FAV: begin
					st_q <= ST_FDIV;
					cnt_q <= 7'd0;
				end
				ST_FDIV, ST_UDIV: begin
					if (cnt_q == 7'd0) begin
						// load: numerator from mprod (av) or tmp (d)
						logic signed [31:0] p;
						logic signed [32:0] pn;
						p = (st_q == ST_FDIV) ? sat32(-66'(mprod_q)) : tmp_q;
						pn = p[31] ? -33'(p) : 33'(p);
						dv_neg_q <= p[31];
						dv_num_q <= 64'(pn) << FRAC_BITS;
						dv_rem_q <= '0;
						dv_q_q <= '0;
						dv_den_q <= lr_q;
						cnt_q <= 7'd1;
					end else if (cnt_q <= 7'd64) begin
						if (rem_sh >= {32'd0, dv_den_q}) begin
							dv_rem_q <= rem_sh - {32'd0, dv_den_q};
							dv_q_q <= {dv_q_q[62:0], 1'b1};
						end else begin
							dv_rem_q <= rem_sh;
							dv_q_q <= {dv_q_q[62:0], 1'b0};
						end
						dv_num_q <= dv_num_q << 1;
						cnt_q <= cnt_q + 7'd1;
					end else begin
						tmp_q <= sat32(dv_neg_q ? -66'(dv_q_q) : 66'(dv_q_q));
						st_q <= (st_q == ST_FDIV) ? ST_FBB : ST_UXB;
						cnt_q <= 7'd0;
					end
				end
				ST_FBB: begin
					if (cnt_q == 7'd0) cnt_q <= 7'd1;
					else begin
						alpha_q <= sat32(66'(alpha_q) + 66'(mprod_q));
						cnt_q <= 7'd0;
						st_q <= ST_FWR;
					end
				end
				ST_FWR: begin
					if (32'(r_q) == 32'(rows_q) - 1) begin
						r_q <= '0;
						s_q <= '0;
						if (32'(ci_q) + 1 >= 32'(cols_q)) begin
							st_q <= ST_DONE;
						end else begin
							cj_q <= ci_q + CA'(1);
							st_q <= ST_URD;
						end
					end else begin
						r_q <= r_q + RA'(1);
						st_q <= ST_FRD;
					end
				end
				ST_URD: st_q <= ST_URD2; // addresses set, data next cycle
				ST_URD2: begin
					vr_q <= v_rd_q;
					xr_q <= vx_rd_q;
					lr_q <= l_rd_q;
					br_q <= b_rd_q;
					st_q <= ST_UVS;
					cnt_q <= 7'd0;
				end
				ST_UVS: begin
					if (cnt_q == 7'd0) cnt_q <= 7'd1;
					else begin
						tmp_q <= sat32(66'(xr_q) - 66'(mprod_q));
						cnt_q <= 7'd0;
						st_q <= ST_UDIV;
					end
				end
				ST_UXB: begin
					if (cnt_q == 7'd0) cnt_q <= 7'd1;
					else begin
						s_q <= sat32(66'(s_q) + 66'(mprod_q));
						cnt_q <= 7'd0;
						st_q <= ST_UWR;
					end
				end
				ST_UWR: begin
					if (32'(r_q) == 32'(rows_q) - 1) begin
						r_q <= '0;
						s_q <= '0;
						if (32'(cj_q) + 1 >= 32'(cols_q)) begin
							ci_q <= ci_q + CA'(1);
							st_q <= ST_COLBEG;
						end else begin
							cj_q <= cj_q + CA'(1);
							st_q <= ST_URD;
						end
					end else begin
						r_q <= r_q + RA'(1);
						st_q <= ST_URD;
					end
				end
				ST_DONE: begin
					rsp_q.l_value <= '0;
					rsp_q.b_value <= '0;
					rsp_q.status <= failed_q;
					rsp_v_q <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/pfc_checker.sv =====
// Port-level checker for the product-form Cholesky block, bound to the top level
`default_nettype none
`include "product_form_cholesky_factor_assert.svh"
module pfc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire logic [30:0] rsp_l
);
	`PFC_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`PFC_ASSERT_IMPL(a_no_req_when_rsp, clk, arst_n, rsp_valid, !req_ready)
	`PFC_ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready, $stable(rsp_l))
endmodule
bind product_form_cholesky_factor pfc_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_l(rsp.data.l_value)
);
`default_nettype wire
